// ===== src/assert_macros.svh =====
// assertion macros shared by the capture measurement modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising edge of clk, suspended while rst_n is low
`define PIMC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// checked at every rising edge of clk, also during reset
`define PIMC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== src/pimc_pkg.sv =====
// shared constants, types and codes of the pwm capture measurement block
package pimc_pkg;

    localparam int CNT_W    = 16;
    localparam int SRC_W    = 28;
    localparam int PRE_W    = 16;
    localparam int FREQ_W   = 36;
    localparam int DUTY_W   = 15;
    localparam int FRAC_W   = 8;
    localparam int PROD_W   = CNT_W + DUTY_W;
    localparam int DIV_N    = FREQ_W;
    localparam int DIV_D    = PRE_W + 1;
    localparam int DIV_CW   = $clog2(DIV_N);
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [DUTY_W-1:0] DUTY_FULL     = DUTY_W'(25600);
    localparam logic [SRC_W-1:0]  SRC_CLK_RESET = SRC_W'(180000000);
    localparam logic [PRE_W-1:0]  PRESCALE_RESET = PRE_W'(179);

    // register index codes, taken from paddr[2]
    localparam logic REG_SRC_CLK  = 1'b0;
    localparam logic REG_PRESCALE = 1'b1;

    typedef enum logic [1:0] {
        PH_RISE = 2'd0,
        PH_FALL = 2'd1,
        PH_NEXT = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        DSEL_RATE = 2'd0,
        DSEL_FREQ = 2'd1,
        DSEL_DUTY = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic     in_ready;
        logic     start_div;
        div_sel_t div_sel;
        logic     save_freq;
        logic     save_duty;
        logic     load_out;
    } pimc_cmd_t;

    typedef struct packed {
        logic meas;
        logic period_zero;
        logic high_zero;
        logic div_done;
        logic out_free;
    } pimc_status_t;

endpackage

// ===== src/pimc_if.sv =====
// word channels of the capture measurement block: edge times in, results out
interface pimc_in_if;
    logic                      valid;
    logic                      ready;
    logic [pimc_pkg::CNT_W-1:0] edge_time;

    modport source (output valid, output edge_time, input ready);
    modport sink (input valid, input edge_time, output ready);
endinterface

interface pimc_out_if;
    logic                        valid;
    logic                        ready;
    logic [pimc_pkg::CNT_W-1:0]  period_ticks;
    logic [pimc_pkg::CNT_W-1:0]  pulse_ticks;
    logic [pimc_pkg::FREQ_W-1:0] frequency_q8;
    logic [pimc_pkg::DUTY_W-1:0] duty_q8;

    modport source (output valid, output period_ticks, output pulse_ticks,
                    output frequency_q8, output duty_q8, input ready);
    modport sink (input valid, input period_ticks, input pulse_ticks,
                  input frequency_q8, input duty_q8, output ready);
endinterface

// ===== src/pimc_div.sv =====
// restoring unsigned divider, one quotient bit per cycle
`include "assert_macros.svh"

module pimc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pimc_pkg::DIV_N-1:0]  dividend,
    input  logic [pimc_pkg::DIV_D-1:0]  divisor,
    output logic [pimc_pkg::DIV_N-1:0]  quotient,
    output logic                        done
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [pimc_pkg::DIV_CW-1:0] cnt_reg, cnt_next;
    logic [pimc_pkg::DIV_D-1:0]  rem_reg, rem_next;
    logic [pimc_pkg::DIV_D-1:0]  dsr_reg, dsr_next;
    logic [pimc_pkg::DIV_N-1:0]  quo_reg, quo_next;

    logic [pimc_pkg::DIV_D:0]    shifted;
    logic [pimc_pkg::DIV_D:0]    diff;
    logic                        ge;

    assign shifted = {rem_reg, quo_reg[pimc_pkg::DIV_N-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign ge      = shifted >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = pimc_pkg::DIV_CW'(pimc_pkg::DIV_N - 1);
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[pimc_pkg::DIV_D-1:0] : shifted[pimc_pkg::DIV_D-1:0];
            quo_next = {quo_reg[pimc_pkg::DIV_N-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

    `PIMC_ASSERT(a_no_restart_busy, start |-> !busy_reg, "divider started while busy")

endmodule

// ===== src/pimc_datapath.sv =====
// measurement state, product register, divider operand select and output register
`include "assert_macros.svh"

module pimc_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [pimc_pkg::SRC_W-1:0]   src_clk_hz,
    input  logic [pimc_pkg::PRE_W-1:0]   prescale,
    input  pimc_pkg::pimc_cmd_t          cmd,
    output pimc_pkg::pimc_status_t       st,
    pimc_in_if.sink                      in_ch,
    pimc_out_if.source                   out_ch
);

    pimc_pkg::phase_t                phase_reg;
    logic [pimc_pkg::CNT_W-1:0]      rise_reg;
    logic [pimc_pkg::CNT_W-1:0]      high_reg;
    logic [pimc_pkg::CNT_W-1:0]      period_reg;
    logic [pimc_pkg::PROD_W-1:0]     prod_reg;
    logic [pimc_pkg::FREQ_W-1:0]     held_freq_reg;
    logic [pimc_pkg::DUTY_W-1:0]     held_duty_reg;
    logic                            out_valid_reg;
    logic [pimc_pkg::CNT_W-1:0]      out_period_reg;
    logic [pimc_pkg::CNT_W-1:0]      out_pulse_reg;
    logic [pimc_pkg::FREQ_W-1:0]     out_freq_reg;
    logic [pimc_pkg::DUTY_W-1:0]     out_duty_reg;

    logic                            fire;
    logic                            edge_nz;
    logic [pimc_pkg::CNT_W-1:0]      diff;
    logic [pimc_pkg::DIV_N-1:0]      div_dividend;
    logic [pimc_pkg::DIV_D-1:0]      div_divisor;
    logic [pimc_pkg::DIV_N-1:0]      div_quo;
    logic                            div_done;
    logic [pimc_pkg::DUTY_W-1:0]     duty_sat;

    assign in_ch.ready = cmd.in_ready;
    assign fire        = in_ch.valid && cmd.in_ready;
    assign edge_nz     = in_ch.edge_time != '0;
    // wraps modulo the counter range
    assign diff        = in_ch.edge_time - rise_reg;

    always_comb
    begin
        case (cmd.div_sel)
            pimc_pkg::DSEL_RATE:
            begin
                div_dividend = pimc_pkg::DIV_N'(src_clk_hz);
                div_divisor  = {1'b0, prescale} + pimc_pkg::DIV_D'(1);
            end
            pimc_pkg::DSEL_FREQ:
            begin
                // tick rate left in the divider, scaled to q8
                div_dividend = {div_quo[pimc_pkg::DIV_N-pimc_pkg::FRAC_W-1:0],
                                {pimc_pkg::FRAC_W{1'b0}}};
                div_divisor  = pimc_pkg::DIV_D'(period_reg);
            end
            pimc_pkg::DSEL_DUTY:
            begin
                div_dividend = pimc_pkg::DIV_N'(prod_reg);
                div_divisor  = pimc_pkg::DIV_D'(period_reg);
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = pimc_pkg::DIV_D'(1);
            end
        endcase
    end

    pimc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_div),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .done     (div_done)
    );

    assign duty_sat = (div_quo > pimc_pkg::DIV_N'(pimc_pkg::DUTY_FULL))
                      ? pimc_pkg::DUTY_FULL : div_quo[pimc_pkg::DUTY_W-1:0];

    always_comb
    begin
        st.meas        = in_ch.valid && edge_nz && (phase_reg == pimc_pkg::PH_NEXT);
        st.period_zero = diff == '0;
        st.high_zero   = high_reg == '0;
        st.div_done    = div_done;
        st.out_free    = !out_valid_reg || out_ch.ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= pimc_pkg::PH_RISE;
            rise_reg      <= '0;
            high_reg      <= '0;
            held_freq_reg <= '0;
            held_duty_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire && edge_nz)
            begin
                case (phase_reg)
                    pimc_pkg::PH_FALL:
                    begin
                        high_reg  <= diff;
                        phase_reg <= pimc_pkg::PH_NEXT;
                    end
                    default:
                    begin
                        // a period-ending rise is also the next first rise
                        rise_reg  <= in_ch.edge_time;
                        phase_reg <= pimc_pkg::PH_FALL;
                    end
                endcase
            end
            if (cmd.save_freq)
                held_freq_reg <= div_quo;
            if (cmd.save_duty)
                held_duty_reg <= duty_sat;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && edge_nz && (phase_reg == pimc_pkg::PH_NEXT))
        begin
            period_reg <= diff;
            prod_reg   <= pimc_pkg::PROD_W'(high_reg) * pimc_pkg::PROD_W'(pimc_pkg::DUTY_FULL);
        end
        if (cmd.load_out)
        begin
            out_period_reg <= period_reg;
            out_pulse_reg  <= high_reg;
            out_freq_reg   <= held_freq_reg;
            out_duty_reg   <= held_duty_reg;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.period_ticks = out_period_reg;
    assign out_ch.pulse_ticks  = out_pulse_reg;
    assign out_ch.frequency_q8 = out_freq_reg;
    assign out_ch.duty_q8      = out_duty_reg;

    `PIMC_ASSERT(a_load_slot_free, cmd.load_out |-> (!out_valid_reg || out_ch.ready), "result overwritten before taken")
    `PIMC_ASSERT_ALWAYS(a_duty_bound, held_duty_reg <= pimc_pkg::DUTY_FULL, "held duty above full scale")

endmodule

// ===== src/pimc_ctrl.sv =====
// sequencer: accepts edges, runs up to three divisions, hands the result out
`include "assert_macros.svh"

module pimc_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pimc_pkg::pimc_status_t  st,
    output pimc_pkg::pimc_cmd_t     cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RATE = 5'b00010,
        S_FREQ = 5'b00100,
        S_DUTY = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = pimc_pkg::DSEL_RATE;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (st.meas)
                begin
                    // zero period keeps the held frequency and duty
                    if (st.period_zero)
                        state_next = S_EMIT;
                    else
                    begin
                        cmd.start_div = 1'b1;
                        state_next    = S_RATE;
                    end
                end
            end
            S_RATE:
            begin
                if (st.div_done)
                begin
                    cmd.start_div = 1'b1;
                    cmd.div_sel   = pimc_pkg::DSEL_FREQ;
                    state_next    = S_FREQ;
                end
            end
            S_FREQ:
            begin
                if (st.div_done)
                begin
                    cmd.save_freq = 1'b1;
                    if (st.high_zero)
                        state_next = S_EMIT;
                    else
                    begin
                        cmd.start_div = 1'b1;
                        cmd.div_sel   = pimc_pkg::DSEL_DUTY;
                        state_next    = S_DUTY;
                    end
                end
            end
            S_DUTY:
            begin
                if (st.div_done)
                begin
                    cmd.save_duty = 1'b1;
                    state_next    = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    `PIMC_ASSERT(a_busy_after_meas, (state_reg == S_IDLE && st.meas) |=> !cmd.in_ready, "edge taken during a measurement")

endmodule

// ===== src/pwm_input_capture_measure_top.sv =====
// PWM input capture measurement block: edge timestamps in, period, pulse, frequency and
// duty out. Edges that do not end a period (first rise, fall, zero stamps) are taken while
// the sequencer is idle. A rise that ends a period blocks the input while one shared
// restoring divider produces one quotient bit per cycle: tick rate, then frequency, then
// duty (no duty pass with a zero pulse, none at all with a zero period), and also until the
// previous result has been taken. Registers: source clock in Hz at address 0, prescaler
// minus one at address 4.
module pwm_input_capture_measure_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pimc_pkg::ADDR_W-1:0]   paddr,
    input  logic [pimc_pkg::DATA_W-1:0]   pwdata,
    output logic [pimc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    pimc_in_if.sink                       in_ch,
    pimc_out_if.source                    out_ch
);

    logic [pimc_pkg::SRC_W-1:0] src_clk_reg;
    logic [pimc_pkg::PRE_W-1:0] prescale_reg;
    logic                       wr_en;
    logic                       reg_sel;

    pimc_pkg::pimc_cmd_t        cmd;
    pimc_pkg::pimc_status_t     st;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_clk_reg  <= pimc_pkg::SRC_CLK_RESET;
            prescale_reg <= pimc_pkg::PRESCALE_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                pimc_pkg::REG_SRC_CLK:  src_clk_reg  <= pwdata[pimc_pkg::SRC_W-1:0];
                pimc_pkg::REG_PRESCALE: prescale_reg <= pwdata[pimc_pkg::PRE_W-1:0];
                default:                src_clk_reg  <= src_clk_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            pimc_pkg::REG_SRC_CLK:  prdata = pimc_pkg::DATA_W'(src_clk_reg);
            pimc_pkg::REG_PRESCALE: prdata = pimc_pkg::DATA_W'(prescale_reg);
            default:                prdata = '0;
        endcase
    end

    pimc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    pimc_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_clk_hz (src_clk_reg),
        .prescale   (prescale_reg),
        .cmd        (cmd),
        .st         (st),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

endmodule

// ===== dv/tb_pwm_input_capture_measure_top.sv =====
// testbench for the pwm capture measurement block: edge stamps in, measurements checked
`timescale 1ns / 100ps

module tb_pwm_input_capture_measure_top;

    localparam int          DRAIN_CYCLES = 150;
    localparam int unsigned SRC_MAX      = (1 << pimc_pkg::SRC_W) - 1;
    localparam int          PHASES       = 7;
    localparam int          EDGES_PER_PHASE = 87;

    localparam logic [pimc_pkg::ADDR_W-1:0] ADDR_SRC_CLK  = {pimc_pkg::REG_SRC_CLK, 2'b00};
    localparam logic [pimc_pkg::ADDR_W-1:0] ADDR_PRESCALE = {pimc_pkg::REG_PRESCALE, 2'b00};

    typedef struct packed {
        logic [pimc_pkg::CNT_W-1:0]  period;
        logic [pimc_pkg::CNT_W-1:0]  pulse;
        logic [pimc_pkg::FREQ_W-1:0] freq;
        logic [pimc_pkg::DUTY_W-1:0] duty;
    } meas_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [pimc_pkg::ADDR_W-1:0] paddr;
    logic [pimc_pkg::DATA_W-1:0] pwdata;
    logic [pimc_pkg::DATA_W-1:0] prdata;
    logic                        pready;

    pimc_in_if  edge_ch ();
    pimc_out_if meas_ch ();

    pwm_input_capture_measure_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (edge_ch),
        .out_ch  (meas_ch)
    );

    always #1 clk = ~clk;

    // measurement predictor state
    pimc_pkg::phase_t            meas_phase = pimc_pkg::PH_RISE;
    logic [pimc_pkg::CNT_W-1:0]  rise_stamp = '0;
    logic [pimc_pkg::CNT_W-1:0]  high_span = '0;
    logic [pimc_pkg::FREQ_W-1:0] freq_held = '0;
    logic [pimc_pkg::DUTY_W-1:0] duty_held = '0;
    logic [pimc_pkg::SRC_W-1:0]  src_hz = pimc_pkg::SRC_CLK_RESET;
    logic [pimc_pkg::PRE_W-1:0]  pre_m1 = pimc_pkg::PRESCALE_RESET;

    meas_t                      meas_q[$];
    logic [pimc_pkg::CNT_W-1:0] edge_q[$];
    logic [pimc_pkg::CNT_W-1:0] tick_now = '0;

    bit in_idle_en = 1'b0;
    bit out_idle_en = 1'b0;
    int in_gap;
    int out_stall;
    int err_cnt = 0;
    int checked_cnt = 0;
    int edges_taken = 0;
    int zeros_taken = 0;
    int settings_cnt = 1;

    function automatic void predict_edge(logic [pimc_pkg::CNT_W-1:0] stamp);
        logic [pimc_pkg::CNT_W-1:0] period;
        bit [63:0]                  rate;
        bit [63:0]                  duty;
        meas_t                      m;
        if (stamp == '0)
            return;
        case (meas_phase)
            pimc_pkg::PH_FALL:
            begin
                high_span  = stamp - rise_stamp;
                meas_phase = pimc_pkg::PH_NEXT;
            end
            pimc_pkg::PH_NEXT:
            begin
                period = stamp - rise_stamp;
                if (period != '0)
                begin
                    rate      = 64'(src_hz) / (64'(pre_m1) + 64'd1);
                    freq_held = pimc_pkg::FREQ_W'((rate << pimc_pkg::FRAC_W) / 64'(period));
                    if (high_span != '0)
                    begin
                        duty = 64'(high_span) * 64'(pimc_pkg::DUTY_FULL) / 64'(period);
                        if (duty > 64'(pimc_pkg::DUTY_FULL))
                            duty = 64'(pimc_pkg::DUTY_FULL);
                        duty_held = pimc_pkg::DUTY_W'(duty);
                    end
                end
                m.period = period;
                m.pulse  = high_span;
                m.freq   = freq_held;
                m.duty   = duty_held;
                meas_q.push_back(m);
                rise_stamp = stamp;
                meas_phase = pimc_pkg::PH_FALL;
            end
            default:
            begin
                rise_stamp = stamp;
                meas_phase = pimc_pkg::PH_FALL;
            end
        endcase
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 60);
    endfunction

    function automatic logic [pimc_pkg::CNT_W-1:0] pick_span();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2, 3: return pimc_pkg::CNT_W'($urandom_range(1, 15));
            4, 5, 6: return pimc_pkg::CNT_W'($urandom_range(16, 4095));
            default: return pimc_pkg::CNT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // edge driver
    always @(posedge clk or negedge rst_n)
    begin : drive_edges
        logic                       nxt_valid;
        logic [pimc_pkg::CNT_W-1:0] nxt_edge;
        if (!rst_n)
        begin
            edge_ch.valid     <= 1'b0;
            edge_ch.edge_time <= '0;
            in_gap = 0;
        end
        else
        begin
            nxt_valid = edge_ch.valid;
            nxt_edge  = edge_ch.edge_time;
            if (edge_ch.valid && edge_ch.ready)
            begin
                predict_edge(edge_ch.edge_time);
                edges_taken++;
                if (edge_ch.edge_time == '0)
                    zeros_taken++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (in_gap > 0)
                    in_gap--;
                else if (edge_q.size() != 0)
                begin
                    nxt_edge  = edge_q.pop_front();
                    nxt_valid = 1'b1;
                    in_gap    = in_idle_en ? pick_gap() : 0;
                end
            end
            edge_ch.valid     <= nxt_valid;
            edge_ch.edge_time <= nxt_edge;
        end
    end

    // measurement monitor and checker
    always @(posedge clk or negedge rst_n)
    begin : check_meas
        meas_t want;
        meas_t got;
        if (!rst_n)
        begin
            meas_ch.ready <= 1'b0;
            out_stall = 0;
        end
        else
        begin
            if (meas_ch.valid && meas_ch.ready)
            begin
                got.period = meas_ch.period_ticks;
                got.pulse  = meas_ch.pulse_ticks;
                got.freq   = meas_ch.frequency_q8;
                got.duty   = meas_ch.duty_q8;
                if (meas_q.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: expected no measurement", $time);
                    $display("%0t: actual   period=%0d pulse=%0d freq_q8=%0d duty_q8=%0d",
                             $time, got.period, got.pulse, got.freq, got.duty);
                end
                else
                begin
                    want = meas_q.pop_front();
                    checked_cnt++;
                    if (got !== want)
                    begin
                        err_cnt++;
                        $display("%0t: expected period=%0d pulse=%0d freq_q8=%0d duty_q8=%0d",
                                 $time, want.period, want.pulse, want.freq, want.duty);
                        $display("%0t: actual   period=%0d pulse=%0d freq_q8=%0d duty_q8=%0d",
                                 $time, got.period, got.pulse, got.freq, got.duty);
                    end
                end
            end
            if (out_stall > 0)
            begin
                out_stall--;
                meas_ch.ready <= 1'b0;
            end
            else if (out_idle_en && $urandom_range(0, 7) == 0)
            begin
                out_stall = pick_gap();
                meas_ch.ready <= 1'b0;
            end
            else
                meas_ch.ready <= 1'b1;
        end
    end

    task automatic write_reg(logic [pimc_pkg::ADDR_W-1:0] addr,
                             logic [pimc_pkg::DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_SRC_CLK)
            src_hz = data[pimc_pkg::SRC_W-1:0];
        else
            pre_m1 = data[pimc_pkg::PRE_W-1:0];
    endtask

    task automatic wait_results();
        do
            @(negedge clk);
        while (edge_q.size() != 0 || edge_ch.valid || meas_q.size() != 0);
    endtask

    task automatic wait_quiet();
        wait_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic push_stamp(logic [pimc_pkg::CNT_W-1:0] stamp, ref int sent);
        edge_q.push_back(stamp);
        if (stamp != '0)
            sent++;
    endtask

    // mostly well-formed fall/rise pairs, some zeros, stray edges and repeats
    task automatic queue_edges(int target);
        int sent;
        int kind;
        sent = 0;
        @(negedge clk);
        while (sent < target)
        begin
            kind = $urandom_range(0, 19);
            if (kind == 0)
                edge_q.push_back('0);
            else if (kind == 1)
                push_stamp(pimc_pkg::CNT_W'($urandom_range(1, 65535)), sent);
            else if (kind == 2)
            begin
                // same stamp twice: zero pulse or zero period
                push_stamp(tick_now, sent);
                push_stamp(tick_now, sent);
            end
            else
            begin
                tick_now += pick_span();
                push_stamp(tick_now, sent);
                tick_now += pick_span();
                push_stamp(tick_now, sent);
            end
            if ($urandom_range(0, 39) == 0)
                wait_results();
        end
    endtask

    initial
    begin : run
        logic [pimc_pkg::DATA_W-1:0] src;
        logic [pimc_pkg::DATA_W-1:0] pre;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        rst_n  <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n  <= 1'b1;
        @(negedge clk);

        // reset settings: ignored stamps in every phase, zero pulse, saturation,
        // zero period, one-tick and full-range periods, counter wrap
        edge_q = '{16'd0, 16'd100, 16'd0, 16'd150, 16'd0, 16'd300, 16'd300, 16'd400,
                   16'hFFFF, 16'd1, 16'd500, 16'd100, 16'd200, 16'd100, 16'd101, 16'd101,
                   16'd102, 16'd100, 16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA};
        wait_quiet();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    src = SRC_MAX;
                    pre = 0;
                end
                1:
                begin
                    src = 1;
                    pre = 32'hFFFF;
                end
                2:
                begin
                    src = SRC_MAX;
                    pre = 32'hFFFF;
                end
                3:
                begin
                    src = 1;
                    pre = 0;
                end
                default:
                begin
                    src = $urandom_range(1, SRC_MAX);
                    pre = $urandom_range(0, 1) ? $urandom_range(0, 255) :
                                                 $urandom_range(0, 65535);
                end
            endcase
            write_reg(ADDR_SRC_CLK, src);
            write_reg(ADDR_PRESCALE, pre);
            settings_cnt++;
            @(negedge clk);
            in_idle_en  = (p == 0) || (p > 1 && $urandom_range(0, 3) != 0);
            out_idle_en = (p == 0) || (p > 1 && $urandom_range(0, 3) != 0);
            queue_edges(EDGES_PER_PHASE);
            wait_quiet();
        end

        $display("edges accepted: %0d (%0d zero stamps), measurements checked: %0d",
                 edges_taken, zeros_taken, checked_cnt);
        $display("register settings used: %0d, including both extremes of each", settings_cnt);
        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("timeout with %0d measurements outstanding", meas_q.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
